/* rtl/core/pca_pkg.sv */
// Shared types, constants and datapath commands for the polygon centroid accumulator.
package pca_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COUNT_BITS = 16;

  localparam logic [1:0] CFG_BOX_MIN_X = 2'd0;
  localparam logic [1:0] CFG_BOX_MIN_Y = 2'd1;
  localparam logic [1:0] CFG_BOX_MAX_X = 2'd2;
  localparam logic [1:0] CFG_BOX_MAX_Y = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FEW       = 2'd1;
  localparam logic [1:0] ST_AREA      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;
  } pca_in_t;

  typedef struct packed {
    logic signed [31:0] centroid_x;
    logic signed [31:0] centroid_y;
    logic [1:0]         status;
  } pca_out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_N,
    OP_SET_N,
    OP_ORIGIN,
    OP_DIFF,
    OP_CROSS_A,
    OP_CROSS_B,
    OP_AREA,
    OP_ACC_AREA,
    OP_W_LO,
    OP_W_HI,
    OP_W_MUL,
    OP_W_ADD,
    OP_ADVANCE,
    OP_FIN_CHECK,
    OP_DIV_U,
    OP_SET_U,
    OP_RANGE,
    OP_SCALE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   axis_y;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic count_zero;
    logic count_ge2;
    logic div_busy;
    logic out_full;
  } dp_stat_t;

endpackage

/* rtl/core/pca_div.sv */
// Shared signed 64-bit restoring divider, one quotient bit per cycle, truncating toward zero.
module pca_div import pca_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [63:0] divisor,
  output logic               busy,
  output logic signed [64:0] quotient
);

  localparam int DW = 64;
  localparam int CW = $clog2(DW);

  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] dvs;
  logic          neg;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted  = {rem[DW-1:0], quo[DW-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = neg ? $signed((DW+1)'(0) - {1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      quo  <= dividend[DW-1] ? DW'(0) - DW'(dividend) : DW'(dividend);
      dvs  <= divisor[DW-1] ? DW'(0) - DW'(divisor) : DW'(divisor);
      neg  <= dividend[DW-1] ^ divisor[DW-1];
    end else if (busy) begin
      rem <= fits ? shifted - {1'b0, dvs} : shifted;
      quo <= {quo[DW-2:0], fits};
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/pca_datapath.sv */
// Datapath: box registers, normalization, fan-triangle accumulation, centroid and output register.
module pca_datapath import pca_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  pca_in_t  in_data,
  input  logic     cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pca_out_t out_data
);

  localparam int NUM_W = 33 + FRAC_BITS;
  localparam int CW    = 64 - FRAC_BITS;
  localparam int LO_W  = CW / 2;
  localparam int HI_W  = CW - LO_W;
  localparam int PW    = 33 + CW + 1;
  localparam int SPW   = FRAC_BITS + 2 + 33;
  localparam logic signed [64:0] Q_MAX = 65'sd2147483647;
  localparam logic signed [64:0] Q_MIN = -65'sd2147483648;
  localparam logic signed [65:0] U_MAX = 66'sd2147483647;
  localparam logic signed [65:0] U_MIN = -66'sd2147483648;
  localparam logic signed [65:0] U_ONE = 66'sd1 <<< FRAC_BITS;
  localparam logic [PW-1:0] LIM_POS = (PW'(1) << 63) - PW'(1);
  localparam logic [PW-1:0] LIM_NEG = PW'(1) << 63;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic signed [31:0] box_min_x, box_min_y, box_max_x, box_max_y;
  logic signed [31:0] vx, vy, nx, ny, origin_x, origin_y, prev_x, prev_y;
  logic signed [31:0] ax, ay, bx, by, cx, cy;
  logic               last_r, ov;
  logic [COUNT_BITS-1:0] count;
  logic signed [63:0] tas, wsx, wsy, p1, p2, m_term, denom;
  logic signed [CW-1:0] c_val;
  logic [CW-1:0]      c_mag;
  logic               c_neg;
  logic signed [32:0] sx, sy;
  logic [33+LO_W-1:0] pp_lo;
  logic [33+HI_W-1:0] pp_hi;
  logic [1:0]         status_r;
  logic signed [65:0] ux, uy;

  logic signed [31:0] sel_v, sel_min, sel_max;
  logic signed [32:0] span33, diff33;
  logic signed [NUM_W-1:0] num;
  logic               div_start, div_busy;
  logic signed [63:0] div_dividend, div_divisor;
  logic signed [64:0] div_q;
  logic signed [31:0] n_sat;
  logic               n_ovf;
  logic signed [32:0] dax, day, dbx, dby;
  logic signed [63:0] dd;
  logic signed [32:0] a_sel;
  logic               a_neg;
  logic [32:0]        a_mag;
  logic [PW-1:0]      prod;
  logic               p_neg, p_ovf;
  logic [64:0]        add_res;
  logic signed [63:0] w_sel;
  logic signed [65:0] t3;
  logic signed [65:0] u_sel;
  logic [FRAC_BITS:0] clamp;
  logic signed [SPW-1:0] sprod;
  logic [31:0]        scaled;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] d);
    if (d[32] != d[31]) begin
      return d[32] ? 32'sh80000000 : 32'sh7fffffff;
    end
    return d[31:0];
  endfunction

  function automatic logic [64:0] add_sat(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return {1'b1, s[64] ? 64'h8000000000000000 : 64'h7fffffffffffffff};
    end
    return {1'b0, s[63:0]};
  endfunction

  assign sel_v   = cmd.axis_y ? vy : vx;
  assign sel_min = cmd.axis_y ? box_min_y : box_min_x;
  assign sel_max = cmd.axis_y ? box_max_y : box_max_x;
  assign span33  = {sel_max[31], sel_max} - {sel_min[31], sel_min};
  assign diff33  = {sel_v[31], sel_v} - {sel_min[31], sel_min};
  assign num     = $signed({diff33, {FRAC_BITS{1'b0}}});

  assign div_start    = (cmd.op == OP_DIV_N) || (cmd.op == OP_DIV_U);
  assign div_dividend = (cmd.op == OP_DIV_U) ? (cmd.axis_y ? wsy : wsx) :
                        $signed({{(64-NUM_W){num[NUM_W-1]}}, num});
  assign div_divisor  = (cmd.op == OP_DIV_U) ? denom :
                        $signed({{31{span33[32]}}, span33});

  pca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    n_ovf = 1'b0;
    n_sat = div_q[31:0];
    if (span33 == 33'sd0) begin
      n_ovf = 1'b1;
      n_sat = '0;
    end else if (div_q > Q_MAX) begin
      n_ovf = 1'b1;
      n_sat = 32'sh7fffffff;
    end else if (div_q < Q_MIN) begin
      n_ovf = 1'b1;
      n_sat = 32'sh80000000;
    end
  end

  assign dax = {prev_x[31], prev_x} - {origin_x[31], origin_x};
  assign day = {prev_y[31], prev_y} - {origin_y[31], origin_y};
  assign dbx = {nx[31], nx} - {origin_x[31], origin_x};
  assign dby = {ny[31], ny} - {origin_y[31], origin_y};
  assign dd  = p1 - p2;

  assign a_sel = cmd.axis_y ? sy : sx;
  assign a_neg = a_sel[32];
  assign a_mag = a_neg ? 33'd0 - 33'(a_sel) : 33'(a_sel);
  assign prod  = {1'b0, pp_hi, {LO_W{1'b0}}} + PW'(pp_lo);
  assign p_neg = a_neg ^ c_neg;
  assign p_ovf = p_neg ? (prod > LIM_NEG) : (prod > LIM_POS);

  assign w_sel   = cmd.axis_y ? wsy : wsx;
  assign add_res = add_sat((cmd.op == OP_ACC_AREA) ? tas : w_sel,
                           (cmd.op == OP_ACC_AREA) ? 64'(c_val) : m_term);

  assign t3 = $signed({{2{tas[63]}}, tas}) + $signed({tas[63], tas, 1'b0});

  assign u_sel = cmd.axis_y ? uy : ux;
  always_comb begin
    if (u_sel < 66'sd0) begin
      clamp = '0;
    end else if (u_sel > U_ONE) begin
      clamp = (FRAC_BITS+1)'(1) << FRAC_BITS;
    end else begin
      clamp = u_sel[FRAC_BITS:0];
    end
  end
  assign sprod  = $signed({1'b0, clamp}) * span33;
  assign scaled = sprod[FRAC_BITS+31:FRAC_BITS] + sel_min;

  assign stat.last       = last_r;
  assign stat.count_zero = (count == '0);
  assign stat.count_ge2  = (count >= COUNT_BITS'(2));
  assign stat.div_busy   = div_busy;
  assign stat.out_full   = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_max_x <= 32'sd65536;
      box_max_y <= 32'sd65536;
      origin_x  <= '0;
      origin_y  <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      count     <= '0;
      tas       <= '0;
      wsx       <= '0;
      wsy       <= '0;
      ov        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOX_MIN_X: box_min_x <= cfg_data;
          CFG_BOX_MIN_Y: box_min_y <= cfg_data;
          CFG_BOX_MAX_X: box_max_x <= cfg_data;
          CFG_BOX_MAX_Y: box_max_y <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          vx     <= in_data.vertex_x;
          vy     <= in_data.vertex_y;
          last_r <= in_data.last_vertex;
        end
        OP_SET_N: begin
          if (cmd.axis_y) ny <= n_sat;
          else nx <= n_sat;
          if (n_ovf) ov <= 1'b1;
        end
        OP_ORIGIN: begin
          origin_x <= nx;
          origin_y <= ny;
        end
        OP_DIFF: begin
          ax <= sat33(dax);
          ay <= sat33(day);
          bx <= sat33(dbx);
          by <= sat33(dby);
          if ((dax[32] != dax[31]) || (day[32] != day[31]) ||
              (dbx[32] != dbx[31]) || (dby[32] != dby[31])) begin
            ov <= 1'b1;
          end
        end
        OP_CROSS_A: p1 <= ax * by;
        OP_CROSS_B: p2 <= ay * bx;
        OP_AREA: begin
          c_val <= dd[63:FRAC_BITS];
          c_neg <= dd[63];
          c_mag <= dd[63] ? CW'(0) - dd[63:FRAC_BITS] : dd[63:FRAC_BITS];
          sx    <= {ax[31], ax} + {bx[31], bx};
          sy    <= {ay[31], ay} + {by[31], by};
        end
        OP_ACC_AREA: begin
          tas <= add_res[63:0];
          if (add_res[64]) ov <= 1'b1;
        end
        OP_W_LO: pp_lo <= a_mag * c_mag[LO_W-1:0];
        OP_W_HI: pp_hi <= a_mag * c_mag[CW-1:LO_W];
        OP_W_MUL: begin
          if (p_ovf) begin
            ov     <= 1'b1;
            m_term <= p_neg ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
          end else begin
            m_term <= p_neg ? $signed(64'd0 - prod[63:0]) : $signed(prod[63:0]);
          end
        end
        OP_W_ADD: begin
          if (cmd.axis_y) wsy <= add_res[63:0];
          else wsx <= add_res[63:0];
          if (add_res[64]) ov <= 1'b1;
        end
        OP_ADVANCE: begin
          prev_x <= nx;
          prev_y <= ny;
          if (count != COUNT_MAX) count <= count + 1'b1;
        end
        OP_FIN_CHECK: begin
          denom <= t3[63:0];
          if (count < COUNT_BITS'(3)) begin
            status_r <= ST_FEW;
          end else if (ov || (tas == 64'sd0) ||
                       (t3[65] != t3[64]) || (t3[64] != t3[63])) begin
            status_r <= ST_AREA;
          end else begin
            status_r <= ST_OK;
          end
        end
        OP_SET_U: begin
          if (cmd.axis_y) uy <= $signed({{34{origin_y[31]}}, origin_y}) + $signed({div_q[64], div_q});
          else ux <= $signed({{34{origin_x[31]}}, origin_x}) + $signed({div_q[64], div_q});
        end
        OP_RANGE: begin
          if ((status_r == ST_OK) &&
              ((ux > U_MAX) || (ux < U_MIN) || (uy > U_MAX) || (uy < U_MIN))) begin
            status_r <= ST_RANGE;
          end
        end
        OP_SCALE: begin
          if (cmd.axis_y) cy <= scaled;
          else cx <= scaled;
        end
        OP_EMIT: begin
          out_valid           <= 1'b1;
          out_data.status     <= status_r;
          out_data.centroid_x <= (status_r == ST_OK) ? cx : 32'sd0;
          out_data.centroid_y <= (status_r == ST_OK) ? cy : 32'sd0;
          origin_x <= '0;
          origin_y <= '0;
          prev_x   <= '0;
          prev_y   <= '0;
          count    <= '0;
          tas      <= '0;
          wsx      <= '0;
          wsy      <= '0;
          ov       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/pca_ctrl.sv */
// Controller state machine that sequences the datapath through each vertex and the final result.
module pca_ctrl import pca_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_DIV_NX, S_WAIT_NX, S_SET_NX, S_DIV_NY, S_WAIT_NY, S_SET_NY,
    S_ORIGIN, S_DIFF, S_CROSS_A, S_CROSS_B, S_AREA, S_ACC_AREA,
    S_WX_LO, S_WX_HI, S_WX_MUL, S_WX_ADD, S_WY_LO, S_WY_HI, S_WY_MUL, S_WY_ADD,
    S_ADVANCE, S_FIN_CHECK, S_DIV_UX, S_WAIT_UX, S_SET_UX, S_DIV_UY, S_WAIT_UY,
    S_SET_UY, S_RANGE, S_SCALE_X, S_SCALE_Y, S_EMIT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.axis_y = 1'b0;
    case (state)
      S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_DIV_NX:    cmd.op = OP_DIV_N;
      S_SET_NX:    cmd.op = OP_SET_N;
      S_DIV_NY:    begin cmd.op = OP_DIV_N; cmd.axis_y = 1'b1; end
      S_SET_NY:    begin cmd.op = OP_SET_N; cmd.axis_y = 1'b1; end
      S_ORIGIN:    cmd.op = OP_ORIGIN;
      S_DIFF:      cmd.op = OP_DIFF;
      S_CROSS_A:   cmd.op = OP_CROSS_A;
      S_CROSS_B:   cmd.op = OP_CROSS_B;
      S_AREA:      cmd.op = OP_AREA;
      S_ACC_AREA:  cmd.op = OP_ACC_AREA;
      S_WX_LO:     cmd.op = OP_W_LO;
      S_WX_HI:     cmd.op = OP_W_HI;
      S_WX_MUL:    cmd.op = OP_W_MUL;
      S_WX_ADD:    cmd.op = OP_W_ADD;
      S_WY_LO:     begin cmd.op = OP_W_LO; cmd.axis_y = 1'b1; end
      S_WY_HI:     begin cmd.op = OP_W_HI; cmd.axis_y = 1'b1; end
      S_WY_MUL:    begin cmd.op = OP_W_MUL; cmd.axis_y = 1'b1; end
      S_WY_ADD:    begin cmd.op = OP_W_ADD; cmd.axis_y = 1'b1; end
      S_ADVANCE:   cmd.op = OP_ADVANCE;
      S_FIN_CHECK: cmd.op = OP_FIN_CHECK;
      S_DIV_UX:    cmd.op = OP_DIV_U;
      S_SET_UX:    cmd.op = OP_SET_U;
      S_DIV_UY:    begin cmd.op = OP_DIV_U; cmd.axis_y = 1'b1; end
      S_SET_UY:    begin cmd.op = OP_SET_U; cmd.axis_y = 1'b1; end
      S_RANGE:     cmd.op = OP_RANGE;
      S_SCALE_X:   cmd.op = OP_SCALE;
      S_SCALE_Y:   begin cmd.op = OP_SCALE; cmd.axis_y = 1'b1; end
      S_EMIT:      cmd.op = stat.out_full ? OP_NONE : OP_EMIT;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:      if (in_valid) state <= S_DIV_NX;
        S_DIV_NX:    state <= S_WAIT_NX;
        S_WAIT_NX:   if (!stat.div_busy) state <= S_SET_NX;
        S_SET_NX:    state <= S_DIV_NY;
        S_DIV_NY:    state <= S_WAIT_NY;
        S_WAIT_NY:   if (!stat.div_busy) state <= S_SET_NY;
        S_SET_NY: begin
          if (stat.count_zero) state <= S_ORIGIN;
          else if (stat.count_ge2) state <= S_DIFF;
          else state <= S_ADVANCE;
        end
        S_ORIGIN:    state <= S_ADVANCE;
        S_DIFF:      state <= S_CROSS_A;
        S_CROSS_A:   state <= S_CROSS_B;
        S_CROSS_B:   state <= S_AREA;
        S_AREA:      state <= S_ACC_AREA;
        S_ACC_AREA:  state <= S_WX_LO;
        S_WX_LO:     state <= S_WX_HI;
        S_WX_HI:     state <= S_WX_MUL;
        S_WX_MUL:    state <= S_WX_ADD;
        S_WX_ADD:    state <= S_WY_LO;
        S_WY_LO:     state <= S_WY_HI;
        S_WY_HI:     state <= S_WY_MUL;
        S_WY_MUL:    state <= S_WY_ADD;
        S_WY_ADD:    state <= S_ADVANCE;
        S_ADVANCE:   state <= stat.last ? S_FIN_CHECK : S_IDLE;
        S_FIN_CHECK: state <= S_DIV_UX;
        S_DIV_UX:    state <= S_WAIT_UX;
        S_WAIT_UX:   if (!stat.div_busy) state <= S_SET_UX;
        S_SET_UX:    state <= S_DIV_UY;
        S_DIV_UY:    state <= S_WAIT_UY;
        S_WAIT_UY:   if (!stat.div_busy) state <= S_SET_UY;
        S_SET_UY:    state <= S_RANGE;
        S_RANGE:     state <= S_SCALE_X;
        S_SCALE_X:   state <= S_SCALE_Y;
        S_SCALE_Y:   state <= S_EMIT;
        S_EMIT:      if (!stat.out_full) state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/polygon_centroid_accumulator.sv */
// Top level of the polygon centroid accumulator: controller plus datapath.
//
//  Channel | Signals                      | Carries
//  --------+------------------------------+--------------------------------------
//  input   | in_valid, in_ready, in_data  | one vertex request with last flag
//  output  | out_valid, out_ready, out_data | centroid and status per polygon
//  config  | cfg_we, cfg_index, cfg_data  | bounding box register writes
//
// After a vertex is accepted, the block stays busy for two passes of the shared divider
// for normalization, plus the fan-triangle multiply and accumulate steps.
// The first and second vertices skip the triangle steps.
// The last vertex adds two more divider passes, range check and scaling.
// One vertex is in work at a time; in_ready is high only while the controller is idle.
// The result waits in an output register; a stalled output holds the block before it emits.
// Reset is synchronous and restores the box registers and clears all accumulators.
module polygon_centroid_accumulator import pca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  pca_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pca_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pca_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
